### hw/rtl/egd_pkg.sv
// Shared types and constants for the elevator group dispatcher.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package egd_pkg;
   localparam int MAX_CARS   = 8;
   localparam int NUM_FLOORS = 64;
   localparam int CAR_W      = $clog2(MAX_CARS);
   localparam int FLOOR_W    = 6;

   typedef enum logic [1:0] {DIR_UP = 2'd0, DIR_DOWN = 2'd1, DIR_IDLE = 2'd2} dir_type;
   typedef enum logic [1:0] {OP_HALL = 2'd0, OP_CAR = 2'd1, OP_TICK = 2'd2,
                             OP_SHUT = 2'd3} op_type;
   typedef enum logic [1:0] {RK_HALL = 2'd0, RK_CAR = 2'd1, RK_STATUS = 2'd2,
                             RK_SHUT = 2'd3} kind_type;
   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FILE, ST_OUT} state_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic [5:0] target_floor;
      logic       hall_direction;
      logic [2:0] car_index;
   } req_type;

   typedef struct packed {
      logic [1:0] result_kind;
      logic [2:0] car_number;
      logic       found_ok;
      logic [5:0] car_floor;
      logic [1:0] car_direction;
      logic       stopped_here;
      logic       last_result;
   } rsp_type;

   typedef struct packed {
      logic [FLOOR_W-1:0] flr;
      logic [1:0]         motion;
      logic [NUM_FLOORS-1:0] up;
      logic [NUM_FLOORS-1:0] down;
   } car_type;
endpackage
`default_nettype wire

### hw/rtl/elevator_group_dispatcher_core.sv
// Top level of the elevator group dispatcher: sequencer, car state, output word.
// Depends on egd_pkg and egd_car_unit.
`timescale 1ns / 1ps
`default_nettype none
// One word in, then one car per cycle goes through a single shared car unit.
// A hall call scans the cars in use (n of them, 1 to 8), then files and
// offers its answer; a car call files in the cycle after it is taken; a tick
// steps one car per cycle, each emitting one status word that must be taken
// before the next car is stepped; a shutdown answers at once. A held answer
// also holds off the next word: the input is not ready while a word is in
// progress or while its answer waits to be taken.
module elevator_group_dispatcher_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  egd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output egd_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [3:0]       csr_data
);
   import egd_pkg::*;
   state_type state_ff, state_in;
   car_type   cars_ff [MAX_CARS];
   logic [3:0] cfg_ff;
   logic running_ff, running_in;
   req_type req_ff;
   rsp_type rsp_ff, rsp_in;
   logic rv_ff, rv_in;
   logic [CAR_W-1:0] idx_ff, idx_in, best_ff, best_in;
   logic found_ff, found_in;
   logic [FLOOR_W-1:0] bestd_ff, bestd_in;
   logic [3:0] n;
   car_type cur, filed, stepped;
   logic stopped, we;
   logic [CAR_W-1:0] sel;
   logic [FLOOR_W-1:0] d;
   logic suit;

   assign n = (cfg_ff == 4'd0) ? 4'd1 : (cfg_ff > 4'(MAX_CARS)) ? 4'(MAX_CARS) : cfg_ff;
   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == ST_IDLE) && !rv_ff;
   assign rsp_valid = rv_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      sel = idx_ff;
      if (state_ff == ST_FILE && req_ff.opcode == OP_HALL) sel = best_ff;
      if (state_ff == ST_FILE && req_ff.opcode == OP_CAR) sel = req_ff.car_index;
   end
   assign cur = cars_ff[sel];

   egd_car_unit u_car (
      .car_i(cur), .floor_i(req_ff.target_floor),
      .internal_i(req_ff.opcode == OP_CAR), .hdir_i(req_ff.hall_direction),
      .filed_o(filed), .stepped_o(stepped), .stopped_o(stopped));

   assign d = (cur.flr > req_ff.target_floor) ? cur.flr - req_ff.target_floor
                                                : req_ff.target_floor - cur.flr;
   assign suit = !(cur.motion == DIR_UP || cur.motion == DIR_DOWN) ||
                 (cur.motion == {1'b0, req_ff.hall_direction} &&
                  ((!req_ff.hall_direction && cur.flr <= req_ff.target_floor) ||
                   (req_ff.hall_direction && cur.flr >= req_ff.target_floor)));

   always_comb begin
      state_in = state_ff; running_in = running_ff;
      rsp_in = rsp_ff; rv_in = rv_ff && !rsp_ready;
      idx_in = idx_ff; best_in = best_ff; found_in = found_ff; bestd_in = bestd_ff;
      we = 1'b0;
      unique case (state_ff)
         ST_IDLE: if (req_valid && req_ready) begin
            idx_in = '0; found_in = 1'b0;
            unique case (req_data.opcode)
               OP_HALL: state_in = ST_SCAN;
               OP_CAR:  state_in = ST_FILE;
               OP_TICK: state_in = ST_OUT;
               default: begin
                  running_in = 1'b0;
                  rsp_in = '{RK_SHUT, 3'd0, 1'b1, 6'd0, DIR_IDLE, 1'b0, 1'b1};
                  rv_in = 1'b1;
               end
            endcase
         end
         ST_SCAN: begin
            if (suit && (!found_ff || d < bestd_ff)) begin
               found_in = 1'b1; best_in = idx_ff; bestd_in = d;
            end
            idx_in = idx_ff + 1'b1;
            if ({1'b0, idx_ff} + 4'd1 == n) state_in = ST_FILE;
         end
         ST_FILE: begin
            state_in = ST_IDLE; rv_in = 1'b1;
            if (req_ff.opcode == OP_HALL) begin
               if (found_ff) begin
                  we = 1'b1;
                  rsp_in = '{RK_HALL, best_ff, 1'b1, filed.flr, filed.motion, 1'b0, 1'b1};
               end else rsp_in = '{RK_HALL, 3'd0, 1'b0, 6'd0, DIR_IDLE, 1'b0, 1'b1};
            end else begin
               if ({1'b0, req_ff.car_index} >= n)
                  rsp_in = '{RK_CAR, req_ff.car_index, 1'b0, 6'd0, DIR_IDLE, 1'b0, 1'b1};
               else begin
                  we = 1'b1;
                  rsp_in = '{RK_CAR, req_ff.car_index, 1'b1, filed.flr, filed.motion,
                             1'b0, 1'b1};
               end
            end
         end
         default: if (!rv_ff || rsp_ready) begin
            we = running_ff;
            rv_in = 1'b1;
            rsp_in = running_ff ?
               '{RK_STATUS, idx_ff, 1'b1, stepped.flr, stepped.motion, stopped, 1'b0} :
               '{RK_STATUS, idx_ff, 1'b1, cur.flr, cur.motion, 1'b0, 1'b0};
            idx_in = idx_ff + 1'b1;
            if ({1'b0, idx_ff} + 4'd1 == n) begin
               rsp_in.last_result = 1'b1; state_in = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; rv_ff <= 1'b0; running_ff <= 1'b1; cfg_ff <= 4'd2;
         for (int i = 0; i < MAX_CARS; i++)
            cars_ff[i] <= '{6'd1, DIR_IDLE, '0, '0};
      end else begin
         state_ff <= state_in; rv_ff <= rv_in; running_ff <= running_in;
         if (csr_valid) cfg_ff <= csr_data;
         if (we) cars_ff[sel] <= (state_ff == ST_FILE) ? filed : stepped;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) req_ff <= req_data;
      rsp_ff <= rsp_in; idx_ff <= idx_in; best_ff <= best_in;
      found_ff <= found_in; bestd_ff <= bestd_in;
   end
endmodule
`default_nettype wire

### hw/rtl/egd_car_unit.sv
// Shared car unit: filing a call into one car and one tick step of one car.
// Depends on egd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module egd_car_unit (
   input  egd_pkg::car_type car_i,
   input  logic [5:0]       floor_i,
   input  logic             internal_i,
   input  logic             hdir_i,
   output egd_pkg::car_type filed_o,
   output egd_pkg::car_type stepped_o,
   output logic             stopped_o
);
   import egd_pkg::*;
   logic [NUM_FLOORS-1:0] fbit, lo_mask, hi_mask, rem;
   logic [FLOOR_W-1:0]    nxt;

   assign fbit = {{(NUM_FLOORS-1){1'b0}}, 1'b1} << floor_i;

   always_comb begin
      filed_o = car_i;
      if (car_i.motion == DIR_UP || car_i.motion == DIR_DOWN) begin
         if (internal_i) begin
            if (floor_i > car_i.flr) filed_o.up = car_i.up | fbit;
            else filed_o.down = car_i.down | fbit;
         end else if (car_i.motion == DIR_UP) begin
            if (!hdir_i && floor_i >= car_i.flr) filed_o.up = car_i.up | fbit;
            else if (hdir_i) filed_o.down = car_i.down | fbit;
         end else begin
            if (hdir_i && floor_i <= car_i.flr) filed_o.down = car_i.down | fbit;
            else if (!hdir_i) filed_o.up = car_i.up | fbit;
         end
      end else begin
         if (floor_i > car_i.flr) filed_o.up = car_i.up | fbit;
         else if (floor_i < car_i.flr) filed_o.down = car_i.down | fbit;
      end
   end

   // lowest set bit of up, highest set bit of down
   assign lo_mask = car_i.up & (~car_i.up + 1'b1);
   always_comb begin
      hi_mask = '0;
      for (int i = 0; i < NUM_FLOORS; i++)
         if (car_i.down[i]) hi_mask = '0 | (NUM_FLOORS'(1) << i);
   end

   always_comb begin
      rem = car_i.up;
      nxt = '0;
      for (int i = 0; i < NUM_FLOORS; i++)
         if (lo_mask[i] || hi_mask[i]) nxt = FLOOR_W'(i);
      if (car_i.motion == DIR_DOWN) begin
         nxt = '0;
         for (int i = 0; i < NUM_FLOORS; i++)
            if (hi_mask[i]) nxt = FLOOR_W'(i);
      end else begin
         nxt = '0;
         for (int i = 0; i < NUM_FLOORS; i++)
            if (lo_mask[i]) nxt = FLOOR_W'(i);
      end
      stepped_o = car_i;
      stopped_o = 1'b0;
      unique case (car_i.motion)
         DIR_UP: begin
            if (car_i.up == '0) stepped_o.motion = DIR_IDLE;
            else begin
               if (nxt > car_i.flr) stepped_o.flr = car_i.flr + 1'b1;
               if (nxt <= stepped_o.flr) begin
                  rem = car_i.up & ~lo_mask;
                  stopped_o = 1'b1;
               end
               stepped_o.up = rem;
               if (rem == '0) stepped_o.motion = DIR_IDLE;
            end
         end
         DIR_DOWN: begin
            rem = car_i.down;
            if (car_i.down == '0) stepped_o.motion = DIR_IDLE;
            else begin
               if (nxt < car_i.flr) stepped_o.flr = car_i.flr - 1'b1;
               if (nxt >= stepped_o.flr) begin
                  rem = car_i.down & ~hi_mask;
                  stopped_o = 1'b1;
               end
               stepped_o.down = rem;
               if (rem == '0) stepped_o.motion = DIR_IDLE;
            end
         end
         default: begin
            if (car_i.up != '0) stepped_o.motion = DIR_UP;
            else if (car_i.down != '0) stepped_o.motion = DIR_DOWN;
            else stepped_o.motion = DIR_IDLE;
         end
      endcase
   end
endmodule
`default_nettype wire
